/* rtl/fmps_pkg.sv */
// Package for the first-minimum parabolic search block: field widths,
// payload structs, register indexes, status codes and reset defaults.
// No dependencies.
package fmps_pkg;

    // Field widths fixed by the interface
    localparam int IN_W     = 16;
    localparam int SQ_W     = 31;             // |x|^2 of a Q2.14 value fits 31 bits
    localparam int MAG_W    = 32;             // squared modulus, Q4.28
    localparam int BIN_W    = 11;             // bin counter, saturates at 2047
    localparam int STEP_W   = 23;
    localparam int POS_W    = 24;
    localparam int STAT_W   = 2;
    localparam int NUM_W    = MAG_W + STEP_W; // |h * (g[b-1] - g[b+1])|
    localparam int DEN_W    = MAG_W + 1;      // |g[b-1] + g[b+1] - 2 g[b]|
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int MAX_BINS_DEF    = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LOW_EDGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_STEP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LIMIT  = 2'd3;

    // Register reset values
    localparam logic [POS_W-1:0]  AXIS_LOW_EDGE_RST = 24'd0;
    localparam logic [STEP_W-1:0] BIN_STEP_RST      = 23'd65536;
    localparam logic [MAG_W-1:0]  CLIP_LIMIT_RST    = 32'd805306368;
    localparam logic [MAG_W-1:0]  ACCEPT_LIMIT_RST  = 32'd268435456;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd2;

    typedef struct packed {
        logic signed [IN_W-1:0] real_part;
        logic signed [IN_W-1:0] imag_part;
        logic                   last_bin;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] minimum_position;
        logic [STAT_W-1:0]       search_status;
    } result_t;

    typedef struct packed {
        logic signed [POS_W-1:0] axis_low_edge;
        logic [STEP_W-1:0]       bin_step;
        logic [MAG_W-1:0]        clip_limit;
        logic [MAG_W-1:0]        accept_limit;
    } cfg_t;

    // One finished profile handed from the front end to the back end
    typedef struct packed {
        logic             found;
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] g_prev;
        logic [MAG_W-1:0] g_mid;
        logic [MAG_W-1:0] g_next;
    } job_t;

endpackage

/* rtl/fmps_front.sv */
// Front end: squared modulus, clipping, three-bin window and first-minimum
// detection; emits one job per profile on the last bin.
// Depends on fmps_pkg.
module fmps_front #(
    parameter int MAX_BINS = fmps_pkg::MAX_BINS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fmps_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  fmps_pkg::in_item_t s_data,
    output logic               job_valid,
    input  logic               job_ready,
    output fmps_pkg::job_t     job
);
    import fmps_pkg::*;

    localparam logic [BIN_W-1:0] MaxBin = BIN_W'(MAX_BINS);
    localparam logic [BIN_W-1:0] MinBin = BIN_W'(4);
    localparam logic [BIN_W-1:0] CntMax = {BIN_W{1'b1}};

    // Square stage
    logic             sq_valid_reg;
    logic             sq_last_reg;
    logic [SQ_W-1:0]  sq_re_reg;
    logic [SQ_W-1:0]  sq_im_reg;

    // Profile state
    logic [MAG_W-1:0] win_reg [3];
    logic [BIN_W-1:0] cnt_reg;
    logic             found_reg;
    logic [BIN_W-1:0] cand_bin_reg;
    logic [MAG_W-1:0] cand_reg [3];

    logic signed [2*IN_W-1:0] prod_re;
    logic signed [2*IN_W-1:0] prod_im;
    logic [MAG_W-1:0] mag_raw;
    logic [MAG_W-1:0] mag;
    logic [BIN_W-1:0] cnt_next;
    logic             take;
    logic             advance;
    logic             fire;

    assign prod_re = s_data.real_part * s_data.real_part;
    assign prod_im = s_data.imag_part * s_data.imag_part;

    // The square stage holds only while a last beat waits on a full queue;
    // no beat is taken while reset is held
    assign advance   = !(sq_valid_reg && sq_last_reg && !job_ready);
    assign s_ready   = advance && aresetn;
    assign fire      = sq_valid_reg && advance;
    assign job_valid = sq_valid_reg && sq_last_reg;

    // Modulus, clip and candidate test
    always_comb begin
        mag_raw  = MAG_W'(sq_re_reg) + MAG_W'(sq_im_reg);
        mag      = (mag_raw > cfg.clip_limit) ? '0 : mag_raw;
        cnt_next = (cnt_reg == CntMax) ? cnt_reg : cnt_reg + 1'b1;
        take     = !found_reg && (cnt_next >= MinBin) && (cnt_next <= MaxBin)
                   && (win_reg[2] > win_reg[1]) && (mag > win_reg[1])
                   && (win_reg[1] < cfg.accept_limit);
    end

    // Job contents include a candidate taken in this very beat
    always_comb begin
        job.found  = found_reg || take;
        job.bin    = take ? cnt_next - BIN_W'(2) : cand_bin_reg;
        job.g_prev = take ? win_reg[0] : cand_reg[0];
        job.g_mid  = take ? win_reg[1] : cand_reg[1];
        job.g_next = take ? win_reg[2] : cand_reg[2];
    end

    // Square stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (advance) begin
            sq_valid_reg <= s_valid;
        end
        if (advance && s_valid) begin
            sq_last_reg <= s_data.last_bin;
            sq_re_reg   <= SQ_W'(unsigned'(prod_re));
            sq_im_reg   <= SQ_W'(unsigned'(prod_im));
        end
    end

    // Profile state update, cleared after the last bin
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && sq_last_reg)) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i]  <= '0;
                cand_reg[i] <= '0;
            end
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            cand_bin_reg <= '0;
        end else if (fire) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= mag;
            cnt_reg    <= cnt_next;
            if (take) begin
                found_reg    <= 1'b1;
                cand_bin_reg <= job.bin;
                cand_reg[0]  <= win_reg[0];
                cand_reg[1]  <= win_reg[1];
                cand_reg[2]  <= win_reg[2];
            end
        end
    end

endmodule

/* rtl/fmps_queue.sv */
// Short job queue between the front and back ends.
// Depends on fmps_pkg.
module fmps_queue #(
    parameter int DEPTH = fmps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    output logic           in_ready,
    input  fmps_pkg::job_t push_data,
    input  logic           pop,
    output logic           out_valid,
    output fmps_pkg::job_t pop_data
);
    import fmps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] Full    = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != Full);
    assign out_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/fmps_back.sv */
// Back end: parabola refinement of one job with a bit-serial divider,
// rounding, saturation and the output register.
// Depends on fmps_pkg.
module fmps_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  fmps_pkg::cfg_t    cfg,
    input  logic              job_valid,
    output logic              job_pop,
    input  fmps_pkg::job_t    job,
    output logic              m_valid,
    input  logic              m_ready,
    output fmps_pkg::result_t m_data
);
    import fmps_pkg::*;

    localparam int A_W   = BIN_W + 1 + STEP_W;   // (2b-1) h
    localparam int Q_W   = NUM_W + 1;            // signed quotient
    localparam int S_W   = Q_W + 2;              // sum of centre and offset
    localparam int DC_W  = $clog2(NUM_W + 1);
    localparam logic [DC_W-1:0] DivSteps = DC_W'(NUM_W);
    localparam logic signed [S_W-1:0] PosMax = S_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [S_W-1:0] PosMin = -PosMax - S_W'(1);

    typedef enum logic [4:0] {
        BK_IDLE = 5'b00001,
        BK_PREP = 5'b00010,
        BK_MULT = 5'b00100,
        BK_DIV  = 5'b01000,
        BK_DONE = 5'b10000
    } bk_state_t;

    bk_state_t state_reg;
    bk_state_t state_next;

    job_t                    job_reg;
    logic signed [DEN_W:0]   d_reg;
    logic signed [MAG_W:0]   diff_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [A_W-1:0]          a_reg;
    logic                    neg_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [DEN_W:0]          rem_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic [DC_W-1:0]         div_cnt_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;

    logic signed [DEN_W:0]   d_next;
    logic signed [MAG_W:0]   diff_next;
    logic [MAG_W:0]          abs_diff;
    logic [DEN_W:0]          abs_d;
    logic [NUM_W-1:0]        num_next;
    logic [BIN_W:0]          odd_bin;
    logic [A_W-1:0]          a_next;
    logic [DEN_W:0]          shifted;
    logic                    ge;
    logic signed [Q_W-1:0]   q_pos;
    logic signed [Q_W-1:0]   q_signed;
    logic signed [S_W-1:0]   half;
    logic signed [S_W-1:0]   v_full;
    logic signed [POS_W-1:0] pos_sat;
    logic                    out_load;

    assign job_pop = (state_reg == BK_IDLE) && job_valid;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Denominator and difference
    always_comb begin
        d_next    = $signed({2'b00, job_reg.g_prev}) + $signed({2'b00, job_reg.g_next})
                    - $signed({1'b0, job_reg.g_mid, 1'b0});
        diff_next = $signed({1'b0, job_reg.g_prev}) - $signed({1'b0, job_reg.g_next});
    end

    // Magnitudes, numerator product and centre product
    always_comb begin
        abs_diff = diff_reg[MAG_W] ? unsigned'(-diff_reg) : unsigned'(diff_reg);
        abs_d    = d_reg[DEN_W] ? unsigned'(-d_reg) : unsigned'(d_reg);
        num_next = abs_diff[MAG_W-1:0] * cfg.bin_step;
        odd_bin  = {job_reg.bin, 1'b0} - (BIN_W+1)'(1);
        a_next   = odd_bin * cfg.bin_step;
    end

    // One restoring division step
    always_comb begin
        shifted = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        ge      = (shifted >= {1'b0, den_reg});
    end

    // Floor quotient, half-step rounding and saturation
    always_comb begin
        q_pos    = $signed({1'b0, quo_reg});
        q_signed = neg_reg ? (-q_pos - Q_W'(rem_reg != '0)) : q_pos;
        half     = ($signed({{(S_W-A_W){1'b0}}, a_reg})
                    + $signed({{(S_W-Q_W){q_signed[Q_W-1]}}, q_signed})
                    + S_W'(1)) >>> 1;
        v_full   = half + $signed({{(S_W-POS_W){cfg.axis_low_edge[POS_W-1]}},
                                   cfg.axis_low_edge});
        if (v_full > PosMax) begin
            pos_sat = PosMax[POS_W-1:0];
        end else if (v_full < PosMin) begin
            pos_sat = PosMin[POS_W-1:0];
        end else begin
            pos_sat = v_full[POS_W-1:0];
        end
    end

    assign out_load = (state_reg == BK_DONE) && (!out_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (job_valid) state_next = BK_PREP;
            end
            BK_PREP: begin
                state_next = BK_MULT;
            end
            BK_MULT: begin
                if (!job_reg.found || d_reg == '0) state_next = BK_DONE;
                else state_next = BK_DIV;
            end
            BK_DIV: begin
                if (div_cnt_reg == DC_W'(1)) state_next = BK_DONE;
            end
            BK_DONE: begin
                if (out_load) state_next = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job;
        end
        if (state_reg == BK_PREP) begin
            d_reg    <= d_next;
            diff_reg <= diff_next;
        end
        if (state_reg == BK_MULT) begin
            den_reg     <= abs_d[DEN_W-1:0];
            a_reg       <= a_next;
            neg_reg     <= diff_reg[MAG_W] ^ d_reg[DEN_W];
            rem_reg     <= '0;
            quo_reg     <= num_next;
            div_cnt_reg <= DivSteps;
            if (!job_reg.found) begin
                status_reg <= ST_NONE;
            end else if (d_reg == '0) begin
                status_reg <= ST_ZERO_DEN;
            end else begin
                status_reg <= ST_FOUND;
            end
        end
        if (state_reg == BK_DIV) begin
            rem_reg     <= ge ? shifted - {1'b0, den_reg} : shifted;
            quo_reg     <= {quo_reg[NUM_W-2:0], ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // Output register; the next job may already be in progress behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_reg.search_status    <= status_reg;
            out_reg.minimum_position <= (status_reg == ST_FOUND) ? pos_sat : '0;
        end
    end

endmodule

/* rtl/first_minimum_parabolic_search.sv */
// Top level of the first-minimum parabolic search block: configuration
// registers, front end, job queue and back end.
// Depends on fmps_pkg, fmps_front, fmps_queue, fmps_back.
//
// Usage:
//   s_valid/s_ready/s_data carry one complex bin per beat; s_data.last_bin
//   closes a profile. m_valid/m_ready/m_data carry one result per profile.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four registers
//   (cfg_ready is high outside reset); write only while the block is idle.
// Throughput: one bin per cycle while s_ready is high. The back end takes
//   one profile at a time with its one-bit-a-cycle divider; profiles coming
//   faster fill the job queue and then hold s_ready low on their last beat.
// Path: a last bin passes the square stage and the job queue, then the back
//   end's prep, mult, div and done states; without a minimum or with a zero
//   denominator the div state is skipped.
// Reset: registers take their defaults, the profile is cleared and no
//   result is pending; s_ready and cfg_ready stay low while reset is held.
// Stall: while m_ready is low the result holds; the back end finishes the
//   next job and waits; the front end takes bins until the queue is full.
module first_minimum_parabolic_search #(
    parameter int MAX_BINS    = fmps_pkg::MAX_BINS_DEF,
    parameter int QUEUE_DEPTH = fmps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fmps_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output fmps_pkg::result_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fmps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fmps_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import fmps_pkg::*;

    cfg_t cfg_reg;
    job_t front_job;
    job_t queue_job;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic back_pop;

    assign cfg_ready = aresetn;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_low_edge <= AXIS_LOW_EDGE_RST;
            cfg_reg.bin_step      <= BIN_STEP_RST;
            cfg_reg.clip_limit    <= CLIP_LIMIT_RST;
            cfg_reg.accept_limit  <= ACCEPT_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_AXIS_LOW_EDGE: cfg_reg.axis_low_edge <= cfg_data[POS_W-1:0];
                CFG_BIN_STEP:      cfg_reg.bin_step      <= cfg_data[STEP_W-1:0];
                CFG_CLIP_LIMIT:    cfg_reg.clip_limit    <= cfg_data[MAG_W-1:0];
                CFG_ACCEPT_LIMIT:  cfg_reg.accept_limit  <= cfg_data[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fmps_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (front_valid),
        .job_ready (queue_ready),
        .job       (front_job)
    );

    fmps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .in_ready  (queue_ready),
        .push_data (front_job),
        .pop       (back_pop),
        .out_valid (queue_valid),
        .pop_data  (queue_job)
    );

    fmps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (queue_valid),
        .job_pop   (back_pop),
        .job       (queue_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Back end only pops a queue that holds a job
    a_pop_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        back_pop |-> queue_valid)
        else $error("back end popped an empty job queue");

    // Input stalls only while a finished profile waits on a full queue
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (front_valid && !queue_ready))
        else $error("input stalled without a full job queue");

    // A result that is not a found minimum carries a zero position
    a_zero_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.search_status != ST_FOUND) |-> (m_data.minimum_position == '0))
        else $error("nonzero position on a result without a minimum");

endmodule

/* sim/tb_first_minimum_parabolic_search.sv */
// Self-checking testbench for first_minimum_parabolic_search: a directed table, then random
// profiles under several register settings, checked against an in-bench predictor.
// Depends on fmps_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_first_minimum_parabolic_search;
    import fmps_pkg::*;

    localparam int PROFILE_BINS = MAX_BINS_DEF;
    localparam int LONG_PROFILE = 1026;
    localparam int DRAIN_CYCLES = 80;     // margin for the back end to finish after the last bin
    localparam int NUM_ROWS     = 25;
    localparam int NUM_SEGS     = 6;

    // Directed row: one bin, plus a hand-typed result where it is obvious
    typedef struct packed {
        logic signed [IN_W-1:0]  re;
        logic signed [IN_W-1:0]  im;
        logic                    last;
        logic                    typed;
        logic signed [POS_W-1:0] pos;
        logic [STAT_W-1:0]       status;
    } bin_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    result_t                m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_AXIS_LOW_EDGE;
    logic [CFG_DAT_W-1:0]   cfg_data  = '0;

    int send_idle_pct = 8;
    int recv_idle_pct = 82;
    int mismatches    = 0;
    int bins_sent     = 0;

    // Register copies
    logic [POS_W-1:0]  axis_edge;
    logic [STEP_W-1:0] step_q16;
    logic [MAG_W-1:0]  clip_q28;
    logic [MAG_W-1:0]  accept_q28;

    // Profile state of the predictor
    logic [MAG_W-1:0] win_mag [3];
    logic [BIN_W-1:0] bins_seen;
    logic             have_valley;
    logic [MAG_W-1:0] valley_mag [3];
    logic [BIN_W-1:0] valley_bin;

    result_t minima_in_flight [$];

    int seg_bins [NUM_SEGS] = '{200, 200, 200, 200, 80, LONG_PROFILE + 20};

    // Directed table: single bin, field extremes with a short profile, zero denominator,
    // symmetric valley, valley in the final two bins, two valleys with a clipped last bin
    bin_row_t bin_table [NUM_ROWS] = '{
        '{16'sd0,     16'sd0,     1'b1, 1'b1, 24'sd0,     ST_NONE},
        '{16'sh8000,  16'sh8000,  1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd32767, 16'sd32767, 1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sh8000,  16'sd32767, 1'b1, 1'b1, 24'sd0,     ST_NONE},
        '{16'sd0,     16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd4096,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd4096,  16'sd4096,  1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd8192,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd0,     16'sd0,     1'b1, 1'b1, 24'sd0,     ST_ZERO_DEN},
        '{16'sd8192,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd0,     16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd8192,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd8192,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd0,     16'sd0,     1'b1, 1'b1, 24'sd98304, ST_FOUND},
        '{16'sd16384, 16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd16384, 16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd0,     16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd16384, 16'sd0,     1'b1, 1'b1, 24'sd0,     ST_NONE},
        '{16'sd8192,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd0,     16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd4096,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd8192,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd0,     16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd8192,  16'sd0,     1'b0, 1'b0, 24'sd0,     ST_FOUND},
        '{16'sd32767, 16'sd32767, 1'b1, 1'b0, 24'sd0,     ST_FOUND}
    };

    always #1 aclk = ~aclk;

    first_minimum_parabolic_search u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    function automatic void clear_profile();
        for (int i = 0; i < 3; i++) begin
            win_mag[i]    = '0;
            valley_mag[i] = '0;
        end
        bins_seen   = '0;
        have_valley = 1'b0;
        valley_bin  = '0;
    endfunction

    // Folds one bin into the profile; returns 1 with the result on the closing bin
    function automatic bit track_first_minimum(input in_item_t it, output result_t res);
        longint re, im, gl, g0, gn, h, d, num, q, v;
        logic [MAG_W-1:0] mag;
        int k;
        re  = $signed(it.real_part);
        im  = $signed(it.imag_part);
        mag = MAG_W'(re * re + im * im);
        if (mag > clip_q28)
            mag = '0;
        if (bins_seen < 11'd2047)
            bins_seen++;
        k = bins_seen;

        // window holds bins k-3..k-1, the candidate is bin k-2
        if (!have_valley && k >= 4 && k <= PROFILE_BINS) begin
            if (win_mag[2] > win_mag[1] && mag > win_mag[1] && win_mag[1] < accept_q28) begin
                have_valley   = 1'b1;
                valley_mag[0] = win_mag[0];
                valley_mag[1] = win_mag[1];
                valley_mag[2] = win_mag[2];
                valley_bin    = BIN_W'(k - 2);
            end
        end
        win_mag[0] = win_mag[1];
        win_mag[1] = win_mag[2];
        win_mag[2] = mag;

        res.minimum_position = '0;
        res.search_status    = ST_NONE;
        if (!it.last_bin)
            return 1'b0;

        // three-point parabola, rounded half up, saturated
        if (have_valley) begin
            gl = longint'(valley_mag[0]);
            g0 = longint'(valley_mag[1]);
            gn = longint'(valley_mag[2]);
            h  = longint'(step_q16);
            d  = gl + gn - 2 * g0;
            if (d == 0) begin
                res.search_status = ST_ZERO_DEN;
            end else begin
                num = h * (gl - gn);
                if (d < 0) begin
                    d   = -d;
                    num = -num;
                end
                q = num / d;
                if (num % d != 0 && num < 0)
                    q--;
                v = longint'($signed(axis_edge))
                    + (((2 * longint'(valley_bin) - 1) * h + q + 1) >>> 1);
                if (v > 64'sd8388607)
                    v = 64'sd8388607;
                if (v < -64'sd8388608)
                    v = -64'sd8388608;
                res.minimum_position = POS_W'(v);
                res.search_status    = ST_FOUND;
            end
        end
        clear_profile();
        return 1'b1;
    endfunction

    // One input beat, with random idle cycles ahead of it
    task automatic send_bin(input in_item_t it, input bit typed, input result_t typed_res);
        result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bins_sent++;
        if (track_first_minimum(it, res))
            minima_in_flight.push_back(typed ? typed_res : res);
    endtask

    // Mostly profiles with a shaped valley, some noise and some very short ones
    task automatic send_random_profile();
        int style, len, dip, amp;
        bit tie, shallow;
        in_item_t it, dip_item;
        style = $urandom_range(99);
        if (style < 65)
            len = $urandom_range(4, 28);
        else if (style < 85)
            len = $urandom_range(1, 30);
        else
            len = $urandom_range(1, 3);
        dip      = (len > 3) ? $urandom_range(2, len - 1) : 2;
        tie      = ($urandom_range(9) == 0);
        shallow  = ($urandom_range(4) == 0);
        dip_item = '0;
        it       = '0;
        for (int i = 1; i <= len; i++) begin
            if (style < 65) begin
                if (tie && i == dip + 1) begin
                    it = dip_item;
                end else begin
                    if (i == dip || (i == dip - 1 && shallow))
                        amp = $urandom_range(0, 9000);
                    else if (i > dip && i <= dip + 2)
                        amp = $urandom_range(9000, 24000);
                    else if (i < dip)
                        amp = $urandom_range(9000, 20000);
                    else
                        amp = $urandom_range(0, 32767);
                    it.real_part = $urandom_range(1) ? IN_W'(-amp) : IN_W'(amp);
                    it.imag_part = IN_W'($urandom_range(0, amp / 8));
                    if ($urandom_range(1))
                        it.imag_part = -it.imag_part;
                end
                if (i == dip)
                    dip_item = it;
            end else if (style < 85) begin
                it.real_part = $signed(IN_W'($urandom)) >>> $urandom_range(0, 3);
                it.imag_part = $signed(IN_W'($urandom)) >>> $urandom_range(0, 3);
            end else begin
                it.real_part = IN_W'($urandom_range(0, 20000));
                it.imag_part = -IN_W'($urandom_range(0, 20000));
            end
            it.last_bin = (i == len);
            send_bin(it, 1'b0, '0);
        end
    endtask

    // Flat profile with one valley right at the bin limit: counted or just past it
    task automatic send_long_profile();
        int dip, amp;
        in_item_t it;
        dip = $urandom_range(PROFILE_BINS - 2, PROFILE_BINS - 1);
        it  = '0;
        for (int i = 1; i <= LONG_PROFILE; i++) begin
            if (i == dip)
                amp = 2000;
            else if (i == dip + 1)
                amp = 14000;
            else if (i == dip + 2)
                amp = 15000;
            else
                amp = 12000;
            it.real_part = $urandom_range(1) ? IN_W'(-amp) : IN_W'(amp);
            it.last_bin  = (i == LONG_PROFILE);
            send_bin(it, 1'b0, '0);
        end
    endtask

    // Writes all four registers back to back
    task automatic write_settings(input logic [POS_W-1:0] axis, input logic [STEP_W-1:0] step,
                                  input logic [MAG_W-1:0] clip, input logic [MAG_W-1:0] accept);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [CFG_DAT_W-1:0] vals [4];
        regs = '{CFG_AXIS_LOW_EDGE, CFG_BIN_STEP, CFG_CLIP_LIMIT, CFG_ACCEPT_LIMIT};
        // unused upper bits carry junk; the block must ignore them
        vals = '{{8'($urandom), axis}, {9'($urandom), step}, clip, accept};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            case (regs[i])
                CFG_AXIS_LOW_EDGE: axis_edge  = vals[i][POS_W-1:0];
                CFG_BIN_STEP:      step_q16   = vals[i][STEP_W-1:0];
                CFG_CLIP_LIMIT:    clip_q28   = vals[i];
                CFG_ACCEPT_LIMIT:  accept_q28 = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits for every pending result, then for the back end to go quiet
    task automatic settle_block();
        while (minima_in_flight.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stalls and field checks
    always @(posedge aclk) begin : result_check
        result_t want;
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (minima_in_flight.size() == 0) begin
                report_mismatch("unrequested result, minimum_position",
                                m_data.minimum_position, 0);
            end else begin
                want = minima_in_flight.pop_front();
                if (m_data.minimum_position !== want.minimum_position)
                    report_mismatch("minimum_position", m_data.minimum_position,
                                    want.minimum_position);
                if (m_data.search_status !== want.search_status)
                    report_mismatch("search_status", m_data.search_status,
                                    want.search_status);
            end
        end
    end

    // Stimulus
    initial begin
        in_item_t it;
        result_t  typed_res;
        int       seg, start;
        axis_edge  = AXIS_LOW_EDGE_RST;
        step_q16   = BIN_STEP_RST;
        clip_q28   = CLIP_LIMIT_RST;
        accept_q28 = ACCEPT_LIMIT_RST;
        clear_profile();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table at reset register values
        for (int r = 0; r < NUM_ROWS; r++) begin
            it.real_part = bin_table[r].re;
            it.imag_part = bin_table[r].im;
            it.last_bin  = bin_table[r].last;
            typed_res.minimum_position = bin_table[r].pos;
            typed_res.search_status    = bin_table[r].status;
            send_bin(it, bin_table[r].typed, typed_res);
        end
        s_valid <= 1'b0;

        // random segments, each under its own register setting
        for (seg = 0; seg < NUM_SEGS; seg++) begin
            settle_block();
            send_idle_pct = (seg < 2) ? 8 : (seg < 4) ? 82 : 0;
            recv_idle_pct = (seg < 2) ? 82 : (seg < 4) ? 8 : 0;
            case (seg)
                0: write_settings(POS_W'($urandom), BIN_STEP_RST, CLIP_LIMIT_RST,
                                  ACCEPT_LIMIT_RST);
                1: write_settings(24'h800000, 23'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: write_settings(24'h7FFFFF, 23'h7FFFFF, CLIP_LIMIT_RST, ACCEPT_LIMIT_RST);
                3: write_settings(POS_W'($urandom), 23'd0,
                                  $urandom_range(32'h3000_0000, 32'hFFFF_FFFF),
                                  $urandom_range(32'h0800_0000, 32'h2000_0000));
                4: write_settings(24'h800000, STEP_W'($urandom_range(1, 4096)), 32'd0, 32'd0);
                default: write_settings(POS_W'($urandom), STEP_W'($urandom_range(1, 1 << 18)),
                                        $urandom_range(32'h1000_0000, 32'hFFFF_FFFF),
                                        $urandom_range(32'h0400_0000, 32'h2000_0000));
            endcase
            start = bins_sent;
            if (seg == NUM_SEGS - 1)
                send_long_profile();
            while (bins_sent - start < seg_bins[seg])
                send_random_profile();
            s_valid <= 1'b0;
        end

        settle_block();
        if (mismatches == 0 && minima_in_flight.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard limit on run time
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

/* first_minimum_parabolic_search.f */
rtl/fmps_pkg.sv
rtl/fmps_front.sv
rtl/fmps_queue.sv
rtl/fmps_back.sv
rtl/first_minimum_parabolic_search.sv
sim/tb_first_minimum_parabolic_search.sv
